### design/nmc_pkg.sv
package nmc_pkg;

	localparam int DATA_W    = 16;
	localparam int PROD_W    = 32;
	localparam int PP_W      = 31;
	localparam int DOT_W     = 44;
	localparam int NORM_W    = 43;
	localparam int THR_W     = 40;
	localparam int MAG_W     = 44;
	localparam int SQ_W      = 88;
	localparam int MUL_W     = SQ_W + MAG_W;
	localparam int MCNT_W    = 6;
	localparam int OUT_CLS_W = 2;

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(17);

	typedef enum logic [1:0] {
		MUL_SQ,
		MUL_LHS,
		MUL_RHS
	} mul_sel_t;

	typedef struct packed {
		logic     clr_step;
		logic     cls_first;
		logic     cls_next;
		logic     mul_start;
		mul_sel_t mul_sel;
		logic     take_sq;
		logic     take_lhs;
		logic     take_best;
		logic     out_load;
	} nmc_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic pipe_busy;
		logic last_accept;
		logic mul_busy;
		logic cls_valid;
		logic cls_last;
		logic quick;
		logic quick_win;
		logic cmp_win;
		logic out_free;
	} nmc_sts_t;

endpackage

### design/nmc_ram.sv
module nmc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1280,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### design/nmc_smul.sv
module nmc_smul
	import nmc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SQ_W-1:0]   a,
	input  logic [MAG_W-1:0]  b,
	output logic              busy,
	output logic [MUL_W-1:0]  prod
);

	// shift-add, one multiplier bit per cycle
	logic [MUL_W-1:0]  a_q;
	logic [MUL_W-1:0]  p_q;
	logic [MAG_W-1:0]  b_q;
	logic [MCNT_W-1:0] cnt_q;

	assign busy = (cnt_q != '0);
	assign prod = p_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= MCNT_W'(MAG_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= MUL_W'(a);
			b_q <= b;
			p_q <= '0;
		end else if (busy) begin
			if (b_q[0]) begin
				p_q <= p_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

endmodule

### design/nmc_datapath.sv
module nmc_datapath
	import nmc_pkg::*;
#(
	parameter int CLASS_CNT   = 4,
	parameter int FEATURE_LEN = 1280
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  nmc_cmd_t              cmd,
	output nmc_sts_t              sts,
	input  logic                  in_acc,
	input  logic                  op,
	input  logic [1:0]            class_index,
	input  logic [10:0]           elem_index,
	input  logic signed [15:0]    elem_value,
	input  logic                  last_elem,
	input  logic                  cfg_we,
	input  logic [THR_W-1:0]      skip_threshold,
	input  logic                  out_stall,
	output logic                  out_valid,
	output logic [OUT_CLS_W-1:0]  predicted_class,
	output logic                  found
);

	localparam int AW = (FEATURE_LEN > 1) ? $clog2(FEATURE_LEN) : 1;
	localparam int CW = (CLASS_CNT > 1) ? $clog2(CLASS_CNT) : 1;

	logic [THR_W-1:0] thr_q;
	logic [AW-1:0]    clr_addr_q;

	logic idx_ok, cls_ok;
	logic [AW-1:0] idx_a;

	assign idx_ok = ({2'b00, elem_index} < 13'(FEATURE_LEN));
	assign cls_ok = ({3'b000, class_index} < 5'(CLASS_CNT));
	assign idx_a  = AW'(elem_index);

	logic signed [DATA_W-1:0] rd [CLASS_CNT];

	for (genvar c = 0; c < CLASS_CNT; c++) begin : g_ram
		logic we;
		assign we = cmd.clr_step ||
			(in_acc && !op && idx_ok && cls_ok && (5'(class_index) == 5'(c)));
		nmc_ram #(.WIDTH(DATA_W), .DEPTH(FEATURE_LEN)) u_ram (
			.clk   (clk),
			.we    (we),
			.waddr (cmd.clr_step ? clr_addr_q : idx_a),
			.wdata (cmd.clr_step ? '0 : elem_value),
			.raddr (idx_a),
			.rdata (rd[c])
		);
	end

	// feature pipeline: s1 = RAM data, s2 = products, then accumulate
	logic v_s1, en_s1, v_s2;
	logic signed [DATA_W-1:0] val_s1;
	logic signed [PROD_W-1:0] fp_s2 [CLASS_CNT];
	logic [PP_W-1:0]          pp_s2 [CLASS_CNT];
	logic signed [DOT_W-1:0]  dot_q [CLASS_CNT];
	logic [NORM_W-1:0]        norm_q [CLASS_CNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_acc && op && idx_ok;
			v_s2 <= v_s1 && en_s1;
		end
	end

	always_ff @(posedge clk) begin
		en_s1  <= idx_ok;
		val_s1 <= elem_value;
	end

	for (genvar c = 0; c < CLASS_CNT; c++) begin : g_mac
		logic signed [PROD_W-1:0] fp, pp;
		logic signed [DOT_W:0]    dsum;
		logic [NORM_W:0]          nsum;

		assign fp   = val_s1 * rd[c];
		assign pp   = rd[c] * rd[c];
		assign dsum = (DOT_W+1)'(dot_q[c]) + (DOT_W+1)'(fp_s2[c]);
		assign nsum = (NORM_W+1)'(norm_q[c]) + (NORM_W+1)'(pp_s2[c]);

		always_ff @(posedge clk) begin
			fp_s2[c] <= fp;
			pp_s2[c] <= PP_W'(pp);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dot_q[c]  <= '0;
				norm_q[c] <= '0;
			end else if (cmd.out_load) begin
				dot_q[c]  <= '0;
				norm_q[c] <= '0;
			end else if (v_s2) begin
				if (dsum[DOT_W] != dsum[DOT_W-1]) begin
					dot_q[c] <= dsum[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}}
						: {1'b0, {(DOT_W-1){1'b1}}};
				end else begin
					dot_q[c] <= dsum[DOT_W-1:0];
				end
				norm_q[c] <= nsum[NORM_W] ? '1 : nsum[NORM_W-1:0];
			end
		end
	end

	// class scan
	logic [CW-1:0]            cls_q;
	logic signed [DOT_W-1:0]  cur_d;
	logic [NORM_W-1:0]        cur_n;
	logic [MAG_W-1:0]         cur_mag;
	logic                     cur_pos, cur_neg;
	logic [SQ_W-1:0]          cur_s_q;
	logic [MUL_W-1:0]         lhs_q;
	logic                     best_found_q, best_pos_q, best_neg_q;
	logic [CW-1:0]            best_idx_q;
	logic [SQ_W-1:0]          best_s_q;
	logic [NORM_W-1:0]        best_n_q;

	assign cur_d   = dot_q[cls_q];
	assign cur_n   = norm_q[cls_q];
	assign cur_neg = cur_d[DOT_W-1];
	assign cur_pos = !cur_neg && (cur_d != '0);
	assign cur_mag = cur_neg ? MAG_W'(-cur_d) : MAG_W'(cur_d);

	logic             mul_busy;
	logic [MUL_W-1:0] mul_p;
	logic [SQ_W-1:0]  mul_a;
	logic [MAG_W-1:0] mul_b;

	always_comb begin
		case (cmd.mul_sel)
			MUL_SQ: begin
				mul_a = SQ_W'(cur_mag);
				mul_b = cur_mag;
			end
			MUL_LHS: begin
				mul_a = cur_s_q;
				mul_b = MAG_W'(best_n_q);
			end
			MUL_RHS: begin
				mul_a = best_s_q;
				mul_b = MAG_W'(cur_n);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	nmc_smul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.prod   (mul_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q        <= THR_RESET;
			clr_addr_q   <= '0;
			cls_q        <= '0;
			best_found_q <= 1'b0;
			out_valid    <= 1'b0;
		end else begin
			if (cfg_we) begin
				thr_q <= skip_threshold;
			end
			if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (cmd.cls_first) begin
				cls_q        <= '0;
				best_found_q <= 1'b0;
			end else begin
				if (cmd.cls_next) begin
					cls_q <= cls_q + 1'b1;
				end
				if (cmd.take_best) begin
					best_found_q <= 1'b1;
				end
			end
			if (cmd.out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_sq) begin
			cur_s_q <= mul_p[SQ_W-1:0];
		end
		if (cmd.take_lhs) begin
			lhs_q <= mul_p;
		end
		if (cmd.take_best) begin
			best_idx_q <= cls_q;
			best_pos_q <= cur_pos;
			best_neg_q <= cur_neg;
			best_s_q   <= cur_s_q;
			best_n_q   <= cur_n;
		end
		if (cmd.out_load) begin
			predicted_class <= best_found_q ? OUT_CLS_W'(best_idx_q) : '0;
			found           <= best_found_q;
		end
	end

	always_comb begin
		sts.clr_done    = (clr_addr_q == AW'(FEATURE_LEN - 1));
		sts.pipe_busy   = v_s1 || v_s2;
		sts.last_accept = in_acc && op && last_elem;
		sts.mul_busy    = mul_busy;
		sts.cls_valid   = (cur_n != '0) && (cur_n >= NORM_W'(thr_q));
		sts.cls_last    = (cls_q == CW'(CLASS_CNT - 1));
		sts.quick       = !best_found_q || (cur_pos != best_pos_q)
			|| (cur_neg != best_neg_q) || (!cur_pos && !cur_neg);
		// sign order decides: positive beats zero beats negative
		sts.quick_win   = !best_found_q || (cur_pos && !best_pos_q)
			|| (!cur_neg && best_neg_q);
		sts.cmp_win     = cur_pos ? (lhs_q > mul_p) : (lhs_q < mul_p);
		sts.out_free    = !out_valid || !out_stall;
	end

`ifndef SYNTHESIS
	a_nofound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (predicted_class == '0))
		else $error("result without valid class must report class 0");
	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> (dot_q[0] == '0 && norm_q[0] == '0))
		else $error("accumulators not cleared after result");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
			(out_valid && $stable(predicted_class) && $stable(found)))
		else $error("stalled result changed");
`endif

endmodule

### design/nmc_ctrl.sv
module nmc_ctrl
	import nmc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  nmc_sts_t sts,
	output nmc_cmd_t cmd,
	output logic     in_stall
);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DRAIN,
		ST_CHECK,
		ST_SQ,
		ST_SQ_W,
		ST_DECIDE,
		ST_LHS,
		ST_LHS_W,
		ST_RHS,
		ST_RHS_W,
		ST_NEXT,
		ST_EMIT
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (sts.last_accept) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) begin
					cmd.cls_first = 1'b1;
					state_d       = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = sts.cls_valid ? ST_SQ : ST_NEXT;
			end
			ST_SQ: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MUL_SQ;
				state_d       = ST_SQ_W;
			end
			ST_SQ_W: begin
				if (!sts.mul_busy) begin
					cmd.take_sq = 1'b1;
					state_d     = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (sts.quick) begin
					cmd.take_best = sts.quick_win;
					state_d       = ST_NEXT;
				end else begin
					state_d = ST_LHS;
				end
			end
			ST_LHS: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MUL_LHS;
				state_d       = ST_LHS_W;
			end
			ST_LHS_W: begin
				cmd.mul_sel = MUL_LHS;
				if (!sts.mul_busy) begin
					cmd.take_lhs = 1'b1;
					state_d      = ST_RHS;
				end
			end
			ST_RHS: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MUL_RHS;
				state_d       = ST_RHS_W;
			end
			ST_RHS_W: begin
				cmd.mul_sel = MUL_RHS;
				if (!sts.mul_busy) begin
					cmd.take_best = sts.cmp_win;
					state_d       = ST_NEXT;
				end
			end
			ST_NEXT: begin
				if (sts.cls_last) begin
					state_d = ST_EMIT;
				end else begin
					cmd.cls_next = 1'b1;
					state_d      = ST_CHECK;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			in_stall <= 1'b1;
		end else begin
			state_q  <= state_d;
			in_stall <= (state_d != ST_IDLE);
		end
	end

`ifndef SYNTHESIS
	a_stall_state: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (state_q != ST_IDLE))
		else $error("stall out of step with state");
	a_mul_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_start |-> !sts.mul_busy)
		else $error("multiplier started while busy");
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded over a pending one");
`endif

endmodule

### design/nearest_mean_classifier_core.sv
// Requests are taken one per cycle while idle; a feature request passes the RAM read,
// the product registers and the saturating add into the accumulators.
// After the last feature the pipeline drains; then a class with a zero norm or below the
// threshold is skipped, and any other class takes one 44-bit shift-add multiply, or three
// if the signs do not decide. Input stays stalled until the result is loaded.
// Reset: prototype RAMs are zeroed one row a cycle, all FEATURE_LEN rows, with in_stall high.
module nearest_mean_classifier_core
	import nmc_pkg::*;
#(
	parameter int CLASS_CNT   = 4,
	parameter int FEATURE_LEN = 1280
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  op,
	input  logic [1:0]            class_index,
	input  logic [10:0]           elem_index,
	input  logic signed [15:0]    elem_value,
	input  logic                  last_elem,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [THR_W-1:0]      skip_threshold,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [OUT_CLS_W-1:0]  predicted_class,
	output logic                  found
);

	nmc_cmd_t cmd;
	nmc_sts_t sts;
	logic     in_acc;

	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	nmc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.sts      (sts),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	nmc_datapath #(
		.CLASS_CNT   (CLASS_CNT),
		.FEATURE_LEN (FEATURE_LEN)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.in_acc          (in_acc),
		.op              (op),
		.class_index     (class_index),
		.elem_index      (elem_index),
		.elem_value      (elem_value),
		.last_elem       (last_elem),
		.cfg_we          (cfg_valid && cfg_ready),
		.skip_threshold  (skip_threshold),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.predicted_class (predicted_class),
		.found           (found)
	);

endmodule

### dv/nearest_mean_classifier_core_tb.sv
`timescale 1ns / 1ps

module nearest_mean_classifier_core_tb;
	import nmc_pkg::*;

	localparam int NCLS = 4;
	localparam int FLEN = 1280;
	localparam int SETTLE = 800;
	localparam logic signed [DOT_W-1:0] DOT_HI = {1'b0, {(DOT_W-1){1'b1}}};
	localparam logic signed [DOT_W-1:0] DOT_LO = {1'b1, {(DOT_W-1){1'b0}}};
	localparam logic [NORM_W-1:0] NORM_HI = '1;

	localparam bit OP_PROTO = 1'b0;
	localparam bit OP_FEAT  = 1'b1;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid, in_stall;
	logic op;
	logic [1:0] class_index;
	logic [10:0] elem_index;
	logic signed [15:0] elem_value;
	logic last_elem;
	logic cfg_valid, cfg_ready;
	logic [THR_W-1:0] skip_threshold;
	logic out_valid, out_stall;
	logic [OUT_CLS_W-1:0] predicted_class;
	logic found;

	nearest_mean_classifier_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .class_index(class_index), .elem_index(elem_index),
		.elem_value(elem_value), .last_elem(last_elem),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .skip_threshold(skip_threshold),
		.out_valid(out_valid), .out_stall(out_stall),
		.predicted_class(predicted_class), .found(found)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// classifier shadow state
	logic signed [15:0] proto_mem [NCLS][FLEN];
	logic signed [DOT_W-1:0] dot_sum [NCLS];
	logic [NORM_W-1:0] norm_sum [NCLS];
	logic [THR_W-1:0] thr_shadow;

	typedef struct packed {
		logic [1:0] cls;
		logic       fnd;
	} verdict_t;
	verdict_t pending_verdicts [$];

	int errors = 0;
	int verdicts_seen = 0;
	longint cyc = 0;

	always @(posedge clk) cyc <= cyc + 1;

	// true if dc/sqrt(nc) > db/sqrt(nb)
	function automatic bit outranks(logic signed [DOT_W-1:0] dc, logic [NORM_W-1:0] nc,
			logic signed [DOT_W-1:0] db, logic [NORM_W-1:0] nb);
		int sc, sb;
		logic [DOT_W-1:0] mc, mb;
		logic [135:0] lhs, rhs;
		sc = dc > 0 ? 1 : (dc < 0 ? -1 : 0);
		sb = db > 0 ? 1 : (db < 0 ? -1 : 0);
		if (sc != sb) return sc > sb;
		if (sc == 0) return 1'b0;
		mc = dc[DOT_W-1] ? ~dc + 1'b1 : dc;
		mb = db[DOT_W-1] ? ~db + 1'b1 : db;
		lhs = 136'(mc) * 136'(mc) * 136'(nb);
		rhs = 136'(mb) * 136'(mb) * 136'(nc);
		return sc > 0 ? (lhs > rhs) : (lhs < rhs);
	endfunction

	task automatic classify(input bit o, input logic [1:0] c, input logic [10:0] ix,
			input logic signed [15:0] v, input bit lst, output bit has, output verdict_t vd);
		logic signed [15:0] p;
		logic signed [31:0] prod, pp;
		logic signed [47:0] d;
		logic [47:0] n;
		int best;
		has = 1'b0;
		vd = '0;
		if (o == OP_PROTO) begin
			if (c < NCLS && ix < FLEN) proto_mem[c][ix] = v;
			return;
		end
		if (ix < FLEN) begin
			for (int k = 0; k < NCLS; k++) begin
				p = proto_mem[k][ix];
				prod = v * p;
				pp = p * p;
				d = 48'(dot_sum[k]) + 48'(prod);
				n = 48'(norm_sum[k]) + 48'(unsigned'(pp));
				if (d > 48'(DOT_HI)) d = 48'(DOT_HI);
				if (d < 48'(DOT_LO)) d = 48'(DOT_LO);
				if (n > 48'(NORM_HI)) n = 48'(NORM_HI);
				dot_sum[k] = d[DOT_W-1:0];
				norm_sum[k] = n[NORM_W-1:0];
			end
		end
		if (!lst) return;
		best = -1;
		for (int k = 0; k < NCLS; k++) begin
			if (norm_sum[k] == 0 || norm_sum[k] < thr_shadow) continue;
			if (best < 0 || outranks(dot_sum[k], norm_sum[k], dot_sum[best], norm_sum[best]))
				best = k;
		end
		has = 1'b1;
		vd.cls = best < 0 ? 2'd0 : 2'(best);
		vd.fnd = best >= 0;
		for (int k = 0; k < NCLS; k++) begin
			dot_sum[k] = '0;
			norm_sum[k] = '0;
		end
	endtask

	// one request; returns right after the accepting edge
	task automatic push_request(input bit o, input logic [1:0] c, input logic [10:0] ix,
			input logic signed [15:0] v, input bit lst, input bit typed, input verdict_t tv);
		bit ok, has;
		verdict_t vd;
		while (!(cyc >= 60000 && cyc < 80000) && $urandom_range(99) < 35) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		class_index <= c;
		elem_index <= ix;
		elem_value <= v;
		last_elem <= lst;
		do begin
			@(negedge clk);
			ok = !in_stall;
			@(posedge clk);
		end while (!ok);
		classify(o, c, ix, v, lst, has, vd);
		if (has) pending_verdicts.push_back(typed ? tv : vd);
	endtask

	task automatic write_threshold(input logic [THR_W-1:0] val);
		bit ok;
		in_valid <= 1'b0;
		wait (pending_verdicts.size() == 0);
		@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		skip_threshold <= val;
		do begin
			@(negedge clk);
			ok = cfg_ready;
			@(posedge clk);
		end while (!ok);
		cfg_valid <= 1'b0;
		thr_shadow = val;
	endtask

	function automatic logic signed [15:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 30) begin
			case ($urandom_range(3))
				0: return 16'sh7fff;
				1: return 16'sh8000;
				2: return 16'sh0000;
				default: return 16'shffff;
			endcase
		end
		if (r < 60) return 16'($signed($urandom_range(4095)) - 2048);
		return 16'($urandom);
	endfunction

	function automatic logic [10:0] pick_index();
		if ($urandom_range(99) < 80) return 11'($urandom_range(15));
		return 11'($urandom_range(2047));
	endfunction

	task automatic random_traffic(input int n);
		int cnt, len, r;
		cnt = 0;
		while (cnt < n) begin
			r = $urandom_range(99);
			if (r < 30) begin
				len = $urandom_range(8, 1);
				for (int j = 0; j < len; j++)
					push_request(OP_PROTO, 2'($urandom), pick_index(), pick_value(),
						1'($urandom), 1'b0, '0);
				cnt += len;
			end else if (r < 85) begin
				len = $urandom_range(10, 1);
				for (int j = 0; j < len; j++)
					push_request(OP_FEAT, 2'($urandom), pick_index(), pick_value(),
						j == len - 1, 1'b0, '0);
				cnt += len;
			end else begin
				push_request(1'($urandom), 2'($urandom), 11'($urandom), 16'($urandom),
					1'($urandom), 1'b0, '0);
				cnt++;
			end
		end
	endtask

	typedef struct packed {
		bit         o;
		logic [1:0] c;
		logic [10:0] ix;
		logic [15:0] v;
		bit         lst;
		bit         typed;
		verdict_t   tv;
	} row_t;

	row_t directed [18] = '{
		'{OP_FEAT,  2'd0, 11'd0,    16'h0000, 1'b1, 1'b1, '{2'd0, 1'b0}}, // empty store
		'{OP_PROTO, 2'd2, 11'd0,    16'h7fff, 1'b0, 1'b0, '0},
		'{OP_PROTO, 2'd1, 11'd0,    16'h8000, 1'b0, 1'b0, '0},
		'{OP_PROTO, 2'd3, 11'd1279, 16'h0001, 1'b0, 1'b0, '0},
		'{OP_PROTO, 2'd0, 11'd1280, 16'h7fff, 1'b0, 1'b0, '0}, // index past end
		'{OP_PROTO, 2'd0, 11'd5,    16'h1234, 1'b1, 1'b0, '0}, // last mark ignored
		'{OP_FEAT,  2'd0, 11'd0,    16'h1000, 1'b1, 1'b1, '{2'd2, 1'b1}},
		'{OP_FEAT,  2'd3, 11'd2047, 16'h7fff, 1'b1, 1'b1, '{2'd0, 1'b0}},
		'{OP_FEAT,  2'd0, 11'd0,    16'h0000, 1'b1, 1'b1, '{2'd1, 1'b1}}, // zero feature
		'{OP_FEAT,  2'd0, 11'd1279, 16'hffff, 1'b1, 1'b1, '{2'd0, 1'b0}}, // below threshold
		'{OP_PROTO, 2'd0, 11'd1,    16'h8000, 1'b0, 1'b0, '0},
		'{OP_PROTO, 2'd1, 11'd1,    16'h0800, 1'b0, 1'b0, '0},
		'{OP_PROTO, 2'd3, 11'd2,    16'h7fff, 1'b0, 1'b0, '0},
		'{OP_FEAT,  2'd2, 11'd1,    16'h7fff, 1'b0, 1'b0, '0},
		'{OP_FEAT,  2'd1, 11'd1,    16'h8000, 1'b0, 1'b0, '0}, // repeated position
		'{OP_FEAT,  2'd0, 11'd1500, 16'h4000, 1'b0, 1'b0, '0},
		'{OP_FEAT,  2'd0, 11'd2,    16'h4000, 1'b1, 1'b0, '0},
		'{OP_FEAT,  2'd0, 11'd2,    16'hc000, 1'b1, 1'b0, '0}
	};

	initial begin
		for (int k = 0; k < NCLS; k++) begin
			dot_sum[k] = '0;
			norm_sum[k] = '0;
			for (int j = 0; j < FLEN; j++) proto_mem[k][j] = '0;
		end
		thr_shadow = THR_RESET;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		op <= OP_PROTO;
		class_index <= '0;
		elem_index <= '0;
		elem_value <= '0;
		last_elem <= 1'b0;
		cfg_valid <= 1'b0;
		skip_threshold <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			push_request(directed[i].o, directed[i].c, directed[i].ix, directed[i].v,
				directed[i].lst, directed[i].typed, directed[i].tv);
		write_threshold('0);
		random_traffic(500);
		write_threshold({THR_W{1'b1}});
		random_traffic(250);
		write_threshold(THR_W'($urandom_range(32'h7fff_ffff)) << $urandom_range(4));
		random_traffic(450);
		write_threshold(THR_RESET);
		random_traffic(400);
		in_valid <= 1'b0;
		wait (pending_verdicts.size() == 0);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// result side; one long hold-off to back the block up
	initial begin
		bit take, held;
		verdict_t got, want;
		held = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(negedge clk);
			take = out_valid && !out_stall;
			got.cls = predicted_class;
			got.fnd = found;
			@(posedge clk);
			if (take) begin
				verdicts_seen++;
				if (pending_verdicts.size() == 0) begin
					$error("result with no request pending: class %0d found %0d",
						got.cls, got.fnd);
					errors++;
				end else begin
					want = pending_verdicts.pop_front();
					if (got.cls !== want.cls) begin
						$error("predicted_class: expected %0d, got %0d", want.cls, got.cls);
						errors++;
					end
					if (got.fnd !== want.fnd) begin
						$error("found: expected %0d, got %0d", want.fnd, got.fnd);
						errors++;
					end
				end
			end
			if (!held && verdicts_seen == 30) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (3000) @(posedge clk);
			end else begin
				out_stall <= (cyc >= 20000 && cyc < 40000) ? 1'b0 : ($urandom_range(99) < 35);
			end
		end
	end

	initial begin
		#100_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
